// ===== src/ddpd_pkg.sv =====
package ddpd_pkg;

  localparam int PIX_W = 8;
  localparam int POS_W = 11;
  localparam int DIM_W = 12;
  localparam int CFG_IDX_W = 2;
  localparam int LINE_W = 2 * PIX_W + 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_THRESHOLD = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RESET     = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET    = 12'd480;
  localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd128;
  localparam logic [DIM_W-1:0] DIM_MIN         = 12'd3;
  localparam logic [DIM_W-1:0] DIM_LIMIT       = 12'd2048;

  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

  // one-hot result kinds, in emission order
  localparam logic [3:0] EMIT_WIN  = 4'b0001;  // (row-1, col-1) from the window
  localparam logic [3:0] EMIT_MID  = 4'b0010;  // (row-1, col) last column
  localparam logic [3:0] EMIT_PREV = 4'b0100;  // (row, col-1) last row
  localparam logic [3:0] EMIT_CUR  = 4'b1000;  // (row, col) last pixel

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [3:0]       emit;
    logic [PIX_W-1:0] pix_win;
    logic [PIX_W-1:0] pix_mid;
    logic [PIX_W-1:0] pix_prev;
    logic [PIX_W-1:0] pix_cur;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } ddpd_job_t;

endpackage

// ===== src/dilated_dark_pixel_difference.sv =====
// Change detector for two aligned binarized frames with a 3x3 dilation
// tolerance on the reference frame.
//
// Input channel (in_valid / in_stall): one transaction per pixel in raster
// order, carrying the reference pixel and the warped pixel of one position.
// Result channel (out_valid / out_stall): one transaction per result pixel,
// tagged with row and column. Results trail the input by one row and one
// column; the last column and last row are flushed as they arrive, so an
// item emits 0, 1, 2 or (last pixel of the frame) 4 results.
// out_end_of_run marks the last result of an item, out_end_of_frame the
// final pixel of the frame.
//
// Items pass the accept-stage, queue and output registers. Throughput: 1
// item per clock through interior rows while out_stall is low; the single
// result port sets the pace on last-column and last-row items (2 results)
// and on the frame's last item (4). A 4-entry job queue sits between the
// classify stage and the output register, so a stalled receiver backs up
// into the queue before in_stall rises. Configuration (cfg_we / cfg_index
// / cfg_data) is written while idle by the user; the block does not check
// it. Reset clears counters, window and queue; line buffers need no clear.
module dilated_dark_pixel_difference
  import ddpd_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     in_ref_pixel,
  input  logic [PIX_W-1:0]     in_warped_pixel,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     out_pixel,
  output logic [POS_W-1:0]     out_row,
  output logic [POS_W-1:0]     out_col,
  output logic                 out_end_of_run,
  output logic                 out_end_of_frame
);

  logic           push, pop, head_valid;
  ddpd_job_t      push_job, head_job;
  logic [QCW-1:0] q_used;

  // front: raster counters, line buffers, 3x3 dark window, job build
  ddpd_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_ref_pixel   (in_ref_pixel),
    .in_warped_pixel(in_warped_pixel),
    .q_used         (q_used),
    .push           (push),
    .push_job       (push_job)
  );

  // jobs that emit at least one result
  ddpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .head_valid(head_valid),
    .head_job  (head_job),
    .used      (q_used)
  );

  // back: expands each job into its results, one per cycle while out_stall is low
  ddpd_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_job        (head_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel       (out_pixel),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_end_of_run  (out_end_of_run),
    .out_end_of_frame(out_end_of_frame)
  );

endmodule

// ===== src/ddpd_ram.sv =====
module ddpd_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// ===== src/ddpd_front.sv =====
module ddpd_front
  import ddpd_pkg::*;
#(
  parameter int MAX_WIDTH = 2048,
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     in_ref_pixel,
  input  logic [PIX_W-1:0]     in_warped_pixel,
  input  logic [QCW-1:0]       q_used,
  output logic                 push,
  output ddpd_job_t            push_job
);

  localparam logic [DIM_W-1:0] WLIM =
    (MAX_WIDTH < 2048) ? DIM_W'(MAX_WIDTH) : DIM_LIMIT;

  logic [DIM_W-1:0] frame_width_r, frame_height_r;
  logic [PIX_W-1:0] dark_threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= WIDTH_RESET;
      frame_height_r   <= HEIGHT_RESET;
      dark_threshold_r <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:    frame_width_r    <= cfg_data;
        CFG_FRAME_HEIGHT:   frame_height_r   <= cfg_data;
        CFG_DARK_THRESHOLD: dark_threshold_r <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] w_eff, h_eff, w_m1, h_m1;
  always_comb begin
    w_eff = (frame_width_r < DIM_MIN) ? DIM_MIN :
            (frame_width_r > WLIM) ? WLIM : frame_width_r;
    h_eff = (frame_height_r < DIM_MIN) ? DIM_MIN :
            (frame_height_r > DIM_LIMIT) ? DIM_LIMIT : frame_height_r;
    w_m1 = w_eff - 12'd1;
    h_m1 = h_eff - 12'd1;
  end

  // ---- accept stage: raster counters and line buffer read ----
  logic [POS_W-1:0] row_r, col_r, row_nxt, col_nxt;
  logic             accept, last_col, last_row;
  logic [31:0]      col32;
  logic [AW-1:0]    idx;
  logic             s1_valid_r;
  logic [QCW:0]     credit_used;

  assign credit_used = {1'b0, q_used} + (QCW+1)'(s1_valid_r);
  assign in_stall    = credit_used >= (QCW+1)'(QDEPTH);
  assign accept      = in_valid && !in_stall;

  assign last_col = {1'b0, col_r} >= w_m1;
  assign last_row = {1'b0, row_r} >= h_m1;
  assign col32    = 32'(col_r);
  assign idx      = (col32 < 32'(MAX_WIDTH)) ? AW'(col32) : AW'(MAX_WIDTH - 1);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r + 11'd1;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + 11'd1;
    end
  end

  logic [PIX_W-1:0] s1_cur_r, s1_wcur_r;
  logic [POS_W-1:0] s1_row_r, s1_col_r;
  logic [AW-1:0]    s1_idx_r;
  logic             s1_last_col_r, s1_last_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur_r      <= in_ref_pixel;
      s1_wcur_r     <= in_warped_pixel;
      s1_row_r      <= row_r;
      s1_col_r      <= col_r;
      s1_idx_r      <= idx;
      s1_last_col_r <= last_col;
      s1_last_row_r <= last_row;
    end
  end

  // line buffer entry: {warped dark flag of row R-1, ref row R-1, ref row R-2}
  logic [LINE_W-1:0] line_rd, line_wr;

  ddpd_ram #(
    .WIDTH(LINE_W),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk    (clk),
    .wr_en  (s1_valid_r),
    .wr_addr(s1_idx_r),
    .wr_data(line_wr),
    .rd_en  (accept),
    .rd_addr(idx),
    .rd_data(line_rd)
  );

  // ---- classify stage: window update and job build ----
  logic [5:0]        window_r;
  logic [LINE_W-1:0] delayed_r;
  logic [PIX_W-1:0]  up, mid;
  logic              wd_prev, wd_cur;
  logic [2:0]        ncol;
  logic              interior, any_dark, row_ge1, col_ge1;
  logic [PIX_W-1:0]  pix_win;

  always_comb begin
    up       = line_rd[PIX_W-1:0];
    mid      = line_rd[2*PIX_W-1:PIX_W];
    wd_prev  = line_rd[LINE_W-1];
    wd_cur   = s1_wcur_r < dark_threshold_r;
    ncol     = {s1_cur_r < dark_threshold_r, mid < dark_threshold_r,
                up < dark_threshold_r};
    line_wr  = {wd_cur, s1_cur_r, mid};
    row_ge1  = s1_row_r != '0;
    col_ge1  = s1_col_r != '0;
    // result (row-1, col-1) is interior when 1 <= row-1 <= h-2, same for col
    interior = (s1_row_r >= 11'd2) && ({1'b0, s1_row_r} <= h_m1) &&
               (s1_col_r >= 11'd2) && ({1'b0, s1_col_r} <= w_m1);
    any_dark = (window_r != '0) || (ncol != '0);
    if (interior) begin
      pix_win = (delayed_r[LINE_W-1] && !any_dark) ? PIX_BLACK : PIX_WHITE;
    end else begin
      pix_win = delayed_r[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= '0;
      delayed_r <= '0;
    end else if (s1_valid_r) begin
      window_r  <= {ncol, window_r[5:3]};
      delayed_r <= {wd_prev, s1_cur_r, mid};
    end
  end

  always_comb begin
    push_job.emit     = ({4{row_ge1 && col_ge1}} & EMIT_WIN) |
                        ({4{row_ge1 && s1_last_col_r}} & EMIT_MID) |
                        ({4{s1_last_row_r && col_ge1}} & EMIT_PREV) |
                        ({4{s1_last_row_r && s1_last_col_r}} & EMIT_CUR);
    push_job.pix_win  = pix_win;
    push_job.pix_mid  = mid;
    push_job.pix_prev = delayed_r[2*PIX_W-1:PIX_W];
    push_job.pix_cur  = s1_cur_r;
    push_job.row      = s1_row_r;
    push_job.col      = s1_col_r;
    push              = s1_valid_r && (push_job.emit != '0);
  end

endmodule

// ===== src/ddpd_queue.sv =====
module ddpd_queue
  import ddpd_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ddpd_job_t      push_job,
  input  logic           pop,
  output logic           head_valid,
  output ddpd_job_t      head_job,
  output logic [QCW-1:0] used
);

  ddpd_job_t      mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] count_r;

  assign head_valid = count_r != '0;
  assign head_job   = mem_r[rd_ptr_r];
  assign used       = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      count_r <= count_r + QCW'(push) - QCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== src/ddpd_emit.sv =====
module ddpd_emit
  import ddpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  ddpd_job_t        head_job,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] out_pixel,
  output logic [POS_W-1:0] out_row,
  output logic [POS_W-1:0] out_col,
  output logic             out_end_of_run,
  output logic             out_end_of_frame
);

  logic [3:0]       done_r, remaining, pick;
  logic             out_valid_r, load, last;
  logic [PIX_W-1:0] pix_sel;
  logic [POS_W-1:0] row_sel, col_sel;

  assign remaining = head_job.emit & ~done_r;
  assign pick      = remaining & (~remaining + 4'd1);
  assign last      = (remaining & ~pick) == '0;
  assign load      = head_valid && (!out_valid_r || !out_stall);
  assign pop       = load && last;

  always_comb begin
    pix_sel = head_job.pix_cur;
    row_sel = head_job.row;
    col_sel = head_job.col;
    case (pick)
      EMIT_WIN: begin
        pix_sel = head_job.pix_win;
        row_sel = head_job.row - 11'd1;
        col_sel = head_job.col - 11'd1;
      end
      EMIT_MID: begin
        pix_sel = head_job.pix_mid;
        row_sel = head_job.row - 11'd1;
      end
      EMIT_PREV: begin
        pix_sel = head_job.pix_prev;
        col_sel = head_job.col - 11'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        done_r <= last ? '0 : (done_r | pick);
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_pixel        <= pix_sel;
      out_row          <= row_sel;
      out_col          <= col_sel;
      out_end_of_run   <= last;
      out_end_of_frame <= pick == EMIT_CUR;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/ddpd_checker.sv =====
module ddpd_checker
  import ddpd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic [PIX_W-1:0] out_pixel,
  input logic [POS_W-1:0] out_row,
  input logic [POS_W-1:0] out_col,
  input logic             out_end_of_run,
  input logic             out_end_of_frame
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      $stable({out_pixel, out_row, out_col, out_end_of_run, out_end_of_frame}))
    else $error("result payload changed while stalled");

  // the final pixel is always the last result of its item
  a_eof_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_frame |-> out_end_of_run)
    else $error("end_of_frame without end_of_run");

  // frames are at least 3x3, so the final pixel never sits at row or column 0
  a_eof_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_frame |-> (out_row >= 11'd2) && (out_col >= 11'd2))
    else $error("end_of_frame at implausible position");

  // nothing is presented right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented after reset");

endmodule

bind dilated_dark_pixel_difference ddpd_checker u_ddpd_checker (.*);

// ===== verif/dilated_dark_pixel_difference_tb.sv =====
`timescale 1ns / 1ps

// Streams binarized frame pairs through the change detector and compares
// every result transaction, field by field, against an in-bench model of the
// line buffers, the 3x3 dark window and the row/column flush rules.
module dilated_dark_pixel_difference_tb;
  import ddpd_pkg::*;

  localparam int QUIET_LIMIT  = 5000;  // cycles with no transaction at all
  localparam int LINE_DEPTH   = 2048;
  localparam int RANDOM_ITEMS = 100;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int SETTLE       = 6;     // > pipeline depth, for row-0 items

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             end_of_run;
    logic             end_of_frame;
  } pix_result_t;

  // DUT ports; every input starts at a known value
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_ref_pixel = '0;
  logic [PIX_W-1:0]     in_warped_pixel = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PIX_W-1:0]     out_pixel;
  logic [POS_W-1:0]     out_row;
  logic [POS_W-1:0]     out_col;
  logic                 out_end_of_run;
  logic                 out_end_of_frame;

  // model state: reference rows R-2 / R-1, warped dark flags of row R-1,
  // dark flags of the two previous columns, and the delayed center column
  logic [PIX_W-1:0] ref_upper [LINE_DEPTH];
  logic [PIX_W-1:0] ref_middle [LINE_DEPTH];
  logic             warp_dark_row [LINE_DEPTH];
  logic [5:0]       dark_cols;
  logic [16:0]      center_delay;
  int unsigned      row_cnt;
  int unsigned      col_cnt;

  // model copy of the register file
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [PIX_W-1:0] thr_reg;

  pix_result_t pending_pixels[$];

  // bookkeeping
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned frames_done = 0;
  int unsigned quiet_cycles = 0;

  // idling knobs, flipped by the tests
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned ref_dark_pct = 10;
  int unsigned warp_dark_pct = 50;

  dilated_dark_pixel_difference dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_ref_pixel    (in_ref_pixel),
    .in_warped_pixel (in_warped_pixel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel       (out_pixel),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_end_of_run  (out_end_of_run),
    .out_end_of_frame(out_end_of_frame)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Random gap length: mostly none or short, now and then a long one.
  // ------------------------------------------------------------------
  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Width/height as the block uses them: clamped to [3, 2048].
  function automatic int unsigned used_dim(input logic [DIM_W-1:0] v);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > DIM_LIMIT) return DIM_LIMIT;
    return v;
  endfunction

  // Mostly binarized pixels, some fully random, some hugging the threshold.
  function automatic logic [PIX_W-1:0] pick_pixel(input int unsigned dark_pct);
    int unsigned mode;
    int          v;
    mode = $urandom_range(0, 9);
    if (mode < 6) return ($urandom_range(0, 99) < dark_pct) ? PIX_BLACK : PIX_WHITE;
    if (mode < 8) return PIX_W'($urandom_range(0, 255));
    v = int'(thr_reg) + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[PIX_W-1:0];
  endfunction

  function automatic pix_result_t make_result(input logic [PIX_W-1:0] pix,
                                              input int unsigned r, input int unsigned c,
                                              input logic eof);
    pix_result_t res;
    res.pixel = pix;
    res.row = r[POS_W-1:0];
    res.col = c[POS_W-1:0];
    res.end_of_run = 1'b0;
    res.end_of_frame = eof;
    return res;
  endfunction

  // ------------------------------------------------------------------
  // Change-map model: one accepted pixel pair in, 0..4 result pixels
  // queued. Window result for (R-1, C-1), then last-column flush of the
  // middle line, last-row flush of the previous column, and the final
  // pixel of the frame.
  // ------------------------------------------------------------------
  task automatic compute_change_pixels(input logic [PIX_W-1:0] cur,
                                       input logic [PIX_W-1:0] wcur);
    int unsigned      w, h, row, col, r, c;
    logic [PIX_W-1:0] up, mid, pix;
    logic             wd_prev, last_col, last_row, interior;
    logic [2:0]       ncol;
    pix_result_t      res[$];
    w = used_dim(width_reg);
    h = used_dim(height_reg);
    row = row_cnt;
    col = col_cnt;
    up = ref_upper[col];
    mid = ref_middle[col];
    wd_prev = warp_dark_row[col];
    ncol = {cur < thr_reg, mid < thr_reg, up < thr_reg};
    last_col = col >= w - 1;
    last_row = row >= h - 1;

    if (row >= 1 && col >= 1) begin
      r = row - 1;
      c = col - 1;
      interior = r >= 1 && r <= h - 2 && c >= 1 && c <= w - 2;
      if (interior) begin
        // new dark: warped dark and nothing dark in the 3x3 reference
        pix = (center_delay[16] && dark_cols == '0 && ncol == '0) ? PIX_BLACK : PIX_WHITE;
      end else begin
        pix = center_delay[7:0];  // border passes reference through
      end
      res = {res, make_result(pix, r, c, 1'b0)};
    end
    if (row >= 1 && last_col) res = {res, make_result(mid, row - 1, col, 1'b0)};
    if (last_row && col >= 1) res = {res, make_result(center_delay[15:8], row, col - 1, 1'b0)};
    if (last_row && last_col) res = {res, make_result(cur, row, col, 1'b1)};
    if (res.size() > 0) res[res.size() - 1].end_of_run = 1'b1;
    pending_pixels = {pending_pixels, res};

    ref_upper[col] = mid;
    ref_middle[col] = cur;
    warp_dark_row[col] = wcur < thr_reg;
    center_delay = {wd_prev, cur, mid};
    dark_cols = {ncol, dark_cols[5:3]};

    if (last_col) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : ((row + 1) & 32'h7FF);
      if (last_row) frames_done++;
    end else begin
      col_cnt = (col + 1) & 32'h7FF;
    end
  endtask

  // ------------------------------------------------------------------
  // Sender: offer one pixel pair, hold it until accepted, then maybe idle.
  // Called at a rising-edge time step.
  // ------------------------------------------------------------------
  task automatic send_pixel(input logic [PIX_W-1:0] refp, input logic [PIX_W-1:0] warp);
    int unsigned gap;
    in_valid <= 1'b1;
    in_ref_pixel <= refp;
    in_warped_pixel <= warp;
    do @(posedge clk); while (in_stall);
    compute_change_pixels(refp, warp);
    items_sent++;
    gap = tx_idle_en ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) send_pixel(pick_pixel(ref_dark_pct), pick_pixel(warp_dark_pct));
  endtask

  // Keep sending until the frame closes (counters back at the origin).
  task automatic finish_frame();
    do send_random(1); while (row_cnt != 0 || col_cnt != 0);
  endtask

  // Sender goes quiet until every expected result is back, plus a few
  // cycles so a row-0 transaction (no result) clears the pipeline too.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH:    width_reg = data;
      CFG_FRAME_HEIGHT:   height_reg = data;
      CFG_DARK_THRESHOLD: thr_reg = data[PIX_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input logic [PIX_W-1:0] thr);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_DARK_THRESHOLD, {{(DIM_W-PIX_W){1'b0}}, thr});
  endtask

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 40) $display("ERROR %0t: %s", $time, msg);
  endtask

  // ------------------------------------------------------------------
  // Receiver: random stall runs, or a long counted hold-off on request.
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (rx_idle_en) stall_left = gap_len();
    end
  end

  // Result checker: each accepted result transaction against the oldest
  // expectation.
  always @(posedge clk) begin : check_results
    pix_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected result pixel %0d at (%0d,%0d)",
                                  out_pixel, out_row, out_col));
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel !== want.pixel)
          report_mismatch($sformatf("pixel at (%0d,%0d): got %0d, expected %0d",
                                    want.row, want.col, out_pixel, want.pixel));
        if (out_row !== want.row)
          report_mismatch($sformatf("row: got %0d, expected %0d", out_row, want.row));
        if (out_col !== want.col)
          report_mismatch($sformatf("col: got %0d, expected %0d", out_col, want.col));
        if (out_end_of_run !== want.end_of_run)
          report_mismatch($sformatf("end_of_run at (%0d,%0d): got %b, expected %b",
                                    want.row, want.col, out_end_of_run, want.end_of_run));
        if (out_end_of_frame !== want.end_of_frame)
          report_mismatch($sformatf("end_of_frame at (%0d,%0d): got %b, expected %b",
                                    want.row, want.col, out_end_of_frame, want.end_of_frame));
      end
    end
  end

  // Watchdog: any transaction on any port resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TIMEOUT: no transaction for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_pixels.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Three 3x3 frames, one interior pixel each.
  task automatic test_directed_patterns();
    // bright reference, warped center just under the top threshold: new dark
    configure(12'd3, 12'd3, 8'd255);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        send_pixel(PIX_WHITE, (r == 1 && c == 1) ? 8'd254 : PIX_WHITE);
    // a dark reference corner inside the window masks a dark warped center;
    // 128 sits exactly at the threshold and is not dark
    configure(12'd3, 12'd3, 8'd128);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        send_pixel((r == 0 && c == 0) ? PIX_BLACK : 8'd128, PIX_BLACK);
    // zero threshold: nothing is dark, interior must be white
    configure(12'd3, 12'd3, 8'd0);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        send_pixel(PIX_BLACK, PIX_BLACK);
  endtask

  // Undersized geometry clamps to 3; oversized geometry clamps to 2048 and
  // is cut short by a shrink a few transactions in.
  task automatic test_clamped_geometry();
    ref_dark_pct = 10;
    warp_dark_pct = 50;
    configure(12'd0, 12'd1, 8'd128);     // 3x3
    finish_frame();
    configure(12'hFFF, 12'd2, 8'd100);   // 2048 wide, 3 tall
    send_random(6);                      // now at row 0, col 6
    write_reg(CFG_FRAME_WIDTH, 12'd5);   // col 6 is past the new last column
    finish_frame();
    configure(12'd2, 12'hFFF, 8'd100);   // 3 wide, 2048 tall
    send_random(3 * 4 + 1);              // now at row 4, col 1
    write_reg(CFG_FRAME_HEIGHT, 12'd4);  // row 4 is past the new last row
    finish_frame();
  endtask

  // Shrink width mid row, then height mid frame: the row closes at the next
  // transaction, the frame at the end of the row in progress.
  task automatic test_shrink_mid_frame();
    configure(12'd8, 12'd6, 8'd128);
    send_random(2 * 8 + 3);              // now at row 2, col 3
    write_reg(CFG_FRAME_WIDTH, 12'd4);   // col 3 becomes the last column
    send_random(5);                      // now at row 4, col 0
    write_reg(CFG_FRAME_HEIGHT, 12'd3);  // row 4 is past the new last row
    finish_frame();
  endtask

  // Receiver holds off for a long stretch while the sender keeps pushing,
  // so the job queue fills and in_stall rises; then the sender pauses
  // mid frame until everything has drained.
  task automatic test_receiver_hold_off();
    configure(12'd16, 12'd4, 8'd128);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_left = HOLD_CYCLES;
    send_random(48);
    wait_drained();
    rx_idle_en = 1'b1;
    finish_frame();
    tx_idle_en = 1'b1;
  endtask

  // Random small frames with random thresholds and idling, a few broken
  // by a mid-frame shrink.
  task automatic test_random_frames();
    int unsigned start, w, h, wu, hu;
    logic [PIX_W-1:0] thr;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 24) : $urandom_range(3, 12);
      h = $urandom_range(3, 6);
      if ($urandom_range(0, 19) == 0) w = $urandom_range(0, 2);
      case ($urandom_range(0, 7))
        0:       thr = 8'd0;
        1:       thr = 8'd255;
        2:       thr = 8'd1;
        default: thr = PIX_W'($urandom_range(0, 255));
      endcase
      configure(DIM_W'(w), DIM_W'(h), thr);
      tx_idle_en = $urandom_range(0, 3) != 0;
      rx_idle_en = $urandom_range(0, 3) != 0;
      ref_dark_pct = $urandom_range(0, 25);
      warp_dark_pct = $urandom_range(20, 80);
      wu = used_dim(DIM_W'(w));
      hu = used_dim(DIM_W'(h));
      if ($urandom_range(0, 5) == 0) begin
        send_random($urandom_range(1, wu * hu - 1));
        if ($urandom_range(0, 1)) write_reg(CFG_FRAME_WIDTH, DIM_W'($urandom_range(0, wu)));
        else write_reg(CFG_FRAME_HEIGHT, DIM_W'($urandom_range(0, hu)));
      end
      finish_frame();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------
  initial begin
    foreach (ref_upper[i]) begin
      ref_upper[i] = '0;
      ref_middle[i] = '0;
      warp_dark_row[i] = 1'b0;
    end
    dark_cols = '0;
    center_delay = '0;
    row_cnt = 0;
    col_cnt = 0;
    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    thr_reg = THRESHOLD_RESET;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_patterns();
    test_clamped_geometry();
    test_shrink_mid_frame();
    test_receiver_hold_off();
    test_random_frames();

    wait_drained();
    repeat (10) @(posedge clk);

    $display("Run covered %0d pixel transactions, %0d result transactions, %0d frames",
             items_sent, results_seen, frames_done);
    $display("Geometry from 3x3 to clamped 2048 settings, thresholds 0..255, %s",
             "mid-frame shrink and a long receiver hold-off");
    if (error_count == 0 && pending_pixels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results never arrived", error_count,
               pending_pixels.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ddpd_pkg.sv
src/ddpd_ram.sv
src/ddpd_front.sv
src/ddpd_queue.sv
src/ddpd_emit.sv
src/dilated_dark_pixel_difference.sv
src/ddpd_checker.sv
verif/dilated_dark_pixel_difference_tb.sv
